// ===== hw/rtl/ccrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ccrs_pkg
// Shared types and constants for the character class run scanner: item
// operation codes, match modes, register indexes and controller states.
// ----------------------------------------------------------------------------
package ccrs_pkg;

  // Byte values index the class table.
  localparam int ADDR_W = 8;
  // Width of the class and length fields on the ports.
  localparam int PORT_CLASS_W = 16;
  localparam int PORT_LEN_W = 16;
  // Register index and data widths of the configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Item operations.
  typedef enum logic [2:0] {
    OP_SET_RANGE   = 3'd0,
    OP_OR_RANGE    = 3'd1,
    OP_CLR_RANGE   = 3'd2,
    OP_CLEAR_TABLE = 3'd3,
    OP_SCAN_BYTE   = 3'd4,
    OP_RESTART     = 3'd5
  } op_t;

  // Class test modes.
  typedef enum logic [2:0] {
    MODE_EQUAL   = 3'd0,
    MODE_ALL     = 3'd1,
    MODE_ANY     = 3'd2,
    MODE_NEQUAL  = 3'd3,
    MODE_NOT_ALL = 3'd4,
    MODE_NONE    = 3'd5
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_FLAGS = 3'd0,
    CFG_MATCH_MODE  = 3'd1,
    CFG_SCAN_KIND   = 3'd2,
    CFG_EOT_MASK    = 3'd3
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_RNG_RD = 2'd2,
    ST_RNG_WR = 2'd3
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/char_class_run_scanner_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// char_class_run_scanner_top
// Byte classifier with a 256-entry class table in a synchronous memory and a
// copy/skip run tracker.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A scan item reads the class table in the
// cycle of acceptance; the test and the result register load follow in the
// scan state, which waits while an earlier result is held in the output
// register. A set, OR or clear range item reads and then writes back each byte
// of the range in turn through the single memory port; a range with a zero
// bound or reversed bounds, and clear table and restart items, finish in the
// cycle of acceptance: clearing drops the per-entry valid bits at once, and an
// entry that is not valid reads as zero. A finished result sits in the output
// register, and the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module char_class_run_scanner_top #(
  parameter int CLASS_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input item channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [2:0]                           in_operation,
  input  wire logic [ccrs_pkg::ADDR_W-1:0]          in_range_from,
  input  wire logic [ccrs_pkg::ADDR_W-1:0]          in_range_to,
  input  wire logic [ccrs_pkg::PORT_CLASS_W-1:0]    in_class_bits,
  input  wire logic [ccrs_pkg::ADDR_W-1:0]          in_text_byte,
  // Result item channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [ccrs_pkg::PORT_CLASS_W-1:0]         out_byte_class,
  output logic [ccrs_pkg::ADDR_W-1:0]               out_byte_echo,
  output logic                                      out_in_run,
  output logic                                      out_run_done,
  output logic                                      out_hit_end,
  output logic [ccrs_pkg::PORT_LEN_W-1:0]           out_run_length,
  // Configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ccrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ccrs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ccrs_pkg::*;

  localparam int ENTRIES = 1 << ADDR_W;
  localparam int CW_IN   = (CLASS_WIDTH < PORT_CLASS_W) ? CLASS_WIDTH : PORT_CLASS_W;
  localparam int CW_CFG  = (CLASS_WIDTH < CFG_DATA_W) ? CLASS_WIDTH : CFG_DATA_W;
  localparam int LEN_OUT = (COUNT_WIDTH < PORT_LEN_W) ? COUNT_WIDTH : PORT_LEN_W;

  // Configuration registers
  logic [CLASS_WIDTH-1:0] match_flags_r;
  mode_t                  match_mode_r;
  logic                   scan_kind_r;
  logic [CLASS_WIDTH-1:0] eot_mask_r;

  // Class table memory, valid bits and read data
  logic [CLASS_WIDTH-1:0] table_mem [ENTRIES];
  logic [ENTRIES-1:0]     entry_vld_r;
  logic [CLASS_WIDTH-1:0] rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   wr_en;
  logic [CLASS_WIDTH-1:0] wr_data;
  logic                   clear_all;

  // Controller state and latched item
  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic [ADDR_W-1:0]      idx_r, idx_nxt;
  logic [ADDR_W-1:0]      to_r, to_nxt;
  logic [CLASS_WIDTH-1:0] bits_r, bits_nxt;
  logic [ADDR_W-1:0]      byte_r, byte_nxt;

  // Run state
  logic [COUNT_WIDTH-1:0] run_count_r, run_count_nxt;
  logic                   run_stopped_r, run_stopped_nxt;
  logic                   at_end_r, at_end_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [CLASS_WIDTH-1:0] out_class_r, out_class_nxt;
  logic [ADDR_W-1:0]      out_echo_r, out_echo_nxt;
  logic                   out_in_run_r, out_in_run_nxt;
  logic                   out_done_r, out_done_nxt;
  logic                   out_end_r, out_end_nxt;
  logic [COUNT_WIDTH-1:0] out_len_r, out_len_nxt;

  // Combinational helpers
  logic                   in_acc;
  op_t                    in_op;
  logic [CLASS_WIDTH-1:0] in_bits;
  logic [CLASS_WIDTH-1:0] cls;
  logic                   test_hit;
  logic                   test_ok;
  logic                   go;
  logic                   range_ok;

  assign in_op    = op_t'(in_operation);
  assign in_bits  = CLASS_WIDTH'(in_class_bits[CW_IN-1:0]);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // An entry never written since the last clear reads as zero.
  assign cls = rd_vld_r ? rd_data_r : '0;

  assign range_ok = (in_range_from != '0) && (in_range_to != '0) &&
                    (in_range_from <= in_range_to);

  // Class test against the match flags.
  always_comb begin
    test_hit = 1'b0;
    test_ok  = 1'b1;
    case (match_mode_r)
      MODE_EQUAL:   test_hit = (cls == match_flags_r);
      MODE_ALL:     test_hit = ((cls & match_flags_r) == match_flags_r);
      MODE_ANY:     test_hit = ((cls & match_flags_r) != '0);
      MODE_NEQUAL:  test_hit = (cls != match_flags_r);
      MODE_NOT_ALL: test_hit = ((cls & match_flags_r) != match_flags_r);
      MODE_NONE:    test_hit = ((cls & match_flags_r) == '0);
      default:      test_ok  = 1'b0;
    endcase
  end

  assign go = test_ok && (scan_kind_r ? !test_hit : test_hit);

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_flags_r <= '0;
      match_mode_r  <= MODE_EQUAL;
      scan_kind_r   <= 1'b0;
      eot_mask_r    <= CLASS_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MATCH_FLAGS: match_flags_r <= CLASS_WIDTH'(cfg_data[CW_CFG-1:0]);
        CFG_MATCH_MODE:  match_mode_r  <= mode_t'(cfg_data[2:0]);
        CFG_SCAN_KIND:   scan_kind_r   <= cfg_data[0];
        CFG_EOT_MASK:    eot_mask_r    <= CLASS_WIDTH'(cfg_data[CW_CFG-1:0]);
        default: ;
      endcase
    end
  end

  // Class table memory: one read or one write per cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
    if (wr_en) begin
      table_mem[idx_r] <= wr_data;
    end
  end

  // Valid bits for the table entries and for the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      if (clear_all) begin
        entry_vld_r <= '0;
      end else if (wr_en) begin
        entry_vld_r[idx_r] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= entry_vld_r[rd_addr];
      end
    end
  end

  // Next state, memory control, run update and result load.
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    to_nxt          = to_r;
    bits_nxt        = bits_r;
    byte_nxt        = byte_r;
    run_count_nxt   = run_count_r;
    run_stopped_nxt = run_stopped_r;
    at_end_nxt      = at_end_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_class_nxt   = out_class_r;
    out_echo_nxt    = out_echo_r;
    out_in_run_nxt  = out_in_run_r;
    out_done_nxt    = out_done_r;
    out_end_nxt     = out_end_r;
    out_len_nxt     = out_len_r;
    rd_en           = 1'b0;
    rd_addr         = idx_r;
    wr_en           = 1'b0;
    wr_data         = bits_r;
    clear_all       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_SET_RANGE, OP_OR_RANGE, OP_CLR_RANGE: begin
              if (range_ok) begin
                op_nxt    = in_op;
                idx_nxt   = in_range_from;
                to_nxt    = in_range_to;
                bits_nxt  = in_bits;
                state_nxt = ST_RNG_RD;
              end
            end
            OP_CLEAR_TABLE: clear_all = 1'b1;
            OP_SCAN_BYTE: begin
              rd_en     = 1'b1;
              rd_addr   = in_text_byte;
              byte_nxt  = in_text_byte;
              state_nxt = ST_SCAN;
            end
            OP_RESTART: begin
              run_count_nxt   = '0;
              run_stopped_nxt = 1'b0;
              at_end_nxt      = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Wait here while an earlier result still sits in the output register.
        if (!out_valid_r || !out_stall) begin
          out_in_run_nxt = 1'b0;
          if (!run_stopped_r) begin
            if ((cls & eot_mask_r) != '0) begin
              run_stopped_nxt = 1'b1;
              at_end_nxt      = 1'b1;
            end else if (go) begin
              out_in_run_nxt = 1'b1;
              if (run_count_r != '1) begin
                run_count_nxt = run_count_r + COUNT_WIDTH'(1);
              end
            end else begin
              run_stopped_nxt = 1'b1;
              at_end_nxt      = 1'b0;
            end
          end
          out_valid_nxt = 1'b1;
          out_class_nxt = cls;
          out_echo_nxt  = byte_r;
          out_done_nxt  = run_stopped_nxt;
          out_end_nxt   = run_stopped_nxt && at_end_nxt;
          // Copy kind reports no length once the run ends on end of text.
          if (run_stopped_nxt && at_end_nxt && !scan_kind_r) begin
            out_len_nxt = '0;
          end else begin
            out_len_nxt = run_count_nxt;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_RNG_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = ST_RNG_WR;
      end

      ST_RNG_WR: begin
        wr_en = 1'b1;
        case (op_r)
          OP_OR_RANGE:  wr_data = cls | bits_r;
          OP_CLR_RANGE: wr_data = cls & ~bits_r;
          default:      wr_data = bits_r;
        endcase
        // The sweep stops at the upper bound and never wraps past the top byte.
        if (idx_r == to_r) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + ADDR_W'(1);
          state_nxt = ST_RNG_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and run state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      run_count_r   <= '0;
      run_stopped_r <= 1'b0;
      at_end_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      run_count_r   <= run_count_nxt;
      run_stopped_r <= run_stopped_nxt;
      at_end_r      <= at_end_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Latched item and result payload.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    to_r         <= to_nxt;
    bits_r       <= bits_nxt;
    byte_r       <= byte_nxt;
    out_class_r  <= out_class_nxt;
    out_echo_r   <= out_echo_nxt;
    out_in_run_r <= out_in_run_nxt;
    out_done_r   <= out_done_nxt;
    out_end_r    <= out_end_nxt;
    out_len_r    <= out_len_nxt;
  end

  // Port drive; wider internal fields are cut to the port widths.
  assign out_valid      = out_valid_r;
  assign out_byte_class = PORT_CLASS_W'(out_class_r[CW_IN-1:0]);
  assign out_byte_echo  = out_echo_r;
  assign out_in_run     = out_in_run_r;
  assign out_run_done   = out_done_r;
  assign out_hit_end    = out_end_r;
  assign out_run_length = PORT_LEN_W'(out_len_r[LEN_OUT-1:0]);

  // A new result only follows a scan evaluation cycle.
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_SCAN)
    else $error("result loaded outside a scan evaluation");

  // A byte inside the run never reports the run as done.
  a_run_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_in_run_r) |-> !out_done_r)
    else $error("byte reported in run after run stopped");

  // End of text is only reported on a stopped run.
  a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> out_done_r)
    else $error("end of text reported on a live run");

  // The range sweep never passes its upper bound.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RNG_WR) |-> (idx_r <= to_r))
    else $error("range sweep past upper bound");

endmodule
`default_nettype wire

// ===== test/char_class_run_scanner_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_class_run_scanner_checker
// Watches the item, result and register channels of the scanner. It keeps its
// own class table, run state and register copies, predicts one result per
// accepted scan item and compares every result item, field by field, with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module char_class_run_scanner_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input item channel
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [2:0]                          in_operation,
  input  logic [ccrs_pkg::ADDR_W-1:0]         in_range_from,
  input  logic [ccrs_pkg::ADDR_W-1:0]         in_range_to,
  input  logic [ccrs_pkg::PORT_CLASS_W-1:0]   in_class_bits,
  input  logic [ccrs_pkg::ADDR_W-1:0]         in_text_byte,
  // Result item channel
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [ccrs_pkg::PORT_CLASS_W-1:0]   out_byte_class,
  input  logic [ccrs_pkg::ADDR_W-1:0]         out_byte_echo,
  input  logic                                out_in_run,
  input  logic                                out_run_done,
  input  logic                                out_hit_end,
  input  logic [ccrs_pkg::PORT_LEN_W-1:0]     out_run_length,
  // Configuration write channel
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [ccrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccrs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Status toward the test top
  output int                                  mismatch_count,
  output int                                  due_count,
  output int                                  checked_count,
  output int                                  run_byte_count,
  output int                                  stop_count,
  output int                                  eot_stop_count
);
  import ccrs_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam logic [PORT_LEN_W-1:0] LEN_MAX = '1;

  // One predicted result item.
  typedef struct packed {
    logic [PORT_CLASS_W-1:0] cls;
    logic [ADDR_W-1:0]       echo;
    logic                    in_run;
    logic                    done;
    logic                    hit_end;
    logic [PORT_LEN_W-1:0]   len;
  } scan_outcome_t;

  scan_outcome_t scan_results_due[$];

  // Predicted block state and register copies.
  logic [PORT_CLASS_W-1:0] class_flags [0:255];
  logic [PORT_LEN_W-1:0]   run_len;
  logic                    run_halted;
  logic                    halted_at_eot;
  logic [PORT_CLASS_W-1:0] want_flags;
  logic [2:0]              test_mode;
  logic                    skip_kind;
  logic [PORT_CLASS_W-1:0] eot_mask;

  task automatic wipe_classes();
    for (int b = 0; b < 256; b++) begin
      class_flags[b] = '0;
    end
  endtask

  // Count a field that differs; only the first few are printed.
  task automatic note_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      if (mismatch_count < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
      mismatch_count++;
    end
  endtask

  // Apply one accepted item to the predicted state; a scan item queues a result.
  task automatic take_item(input logic [2:0] op, input logic [ADDR_W-1:0] from,
                           input logic [ADDR_W-1:0] to, input logic [PORT_CLASS_W-1:0] bits,
                           input logic [ADDR_W-1:0] ch);
    scan_outcome_t o;
    logic [PORT_CLASS_W-1:0] cls;
    logic t;
    logic usable;
    o = '0;
    case (op)
      OP_SET_RANGE, OP_OR_RANGE, OP_CLR_RANGE: begin
        // A zero bound disables the item; reversed bounds make the loop empty.
        if (from != '0 && to != '0) begin
          for (int b = int'(from); b <= int'(to); b++) begin
            case (op)
              OP_SET_RANGE: class_flags[b] = bits;
              OP_OR_RANGE:  class_flags[b] = class_flags[b] | bits;
              default:      class_flags[b] = class_flags[b] & ~bits;
            endcase
          end
        end
      end
      OP_CLEAR_TABLE: wipe_classes();
      OP_RESTART: begin
        run_len = '0;
        run_halted = 1'b0;
        halted_at_eot = 1'b0;
      end
      OP_SCAN_BYTE: begin
        cls = class_flags[ch];
        if (!run_halted) begin
          if ((cls & eot_mask) != '0) begin
            run_halted = 1'b1;
            halted_at_eot = 1'b1;
            eot_stop_count++;
          end else begin
            usable = 1'b1;
            case (test_mode)
              MODE_EQUAL:   t = (cls == want_flags);
              MODE_ALL:     t = ((cls & want_flags) == want_flags);
              MODE_ANY:     t = ((cls & want_flags) != '0);
              MODE_NEQUAL:  t = (cls != want_flags);
              MODE_NOT_ALL: t = ((cls & want_flags) != want_flags);
              MODE_NONE:    t = ((cls & want_flags) == '0);
              default: begin
                t = 1'b0;
                usable = 1'b0;
              end
            endcase
            // Copy kind keeps going while the test holds, skip kind while it fails.
            if (usable && (t ^ skip_kind)) begin
              o.in_run = 1'b1;
              run_byte_count++;
              if (run_len != LEN_MAX) begin
                run_len = run_len + 1'b1;
              end
            end else begin
              run_halted = 1'b1;
              halted_at_eot = 1'b0;
            end
          end
          if (run_halted) begin
            stop_count++;
          end
        end
        o.cls = cls;
        o.echo = ch;
        o.done = run_halted;
        o.hit_end = run_halted && halted_at_eot;
        o.len = (run_halted && halted_at_eot && !skip_kind) ? '0 : run_len;
        scan_results_due.push_back(o);
      end
      default: ;
    endcase
  endtask

  // All channels are sampled at the rising edge.
  always @(posedge clk) begin : watch
    scan_outcome_t want;
    if (!rst_n) begin
      wipe_classes();
      run_len = '0;
      run_halted = 1'b0;
      halted_at_eot = 1'b0;
      want_flags = '0;
      test_mode = MODE_EQUAL;
      skip_kind = 1'b0;
      eot_mask = 16'h0001;
      scan_results_due.delete();
    end else begin
      // Results first: a result never belongs to an item taken at the same edge.
      if (out_valid && !out_stall) begin
        if (scan_results_due.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: result item with nothing expected, byte_echo 0x%0h",
                     $time, out_byte_echo);
          end
          mismatch_count++;
        end else begin
          want = scan_results_due.pop_front();
          checked_count++;
          note_field("byte_class", want.cls, out_byte_class);
          note_field("byte_echo", 16'(want.echo), 16'(out_byte_echo));
          note_field("in_run", 16'(want.in_run), 16'(out_in_run));
          note_field("run_done", 16'(want.done), 16'(out_run_done));
          note_field("hit_end", 16'(want.hit_end), 16'(out_hit_end));
          note_field("run_length", want.len, out_run_length);
        end
      end
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MATCH_FLAGS: want_flags = cfg_data;
          CFG_MATCH_MODE:  test_mode = cfg_data[2:0];
          CFG_SCAN_KIND:   skip_kind = cfg_data[0];
          CFG_EOT_MASK:    eot_mask = cfg_data;
          default: ;
        endcase
      end
      // Accepted input items.
      if (in_valid && !in_stall) begin
        take_item(in_operation, in_range_from, in_range_to, in_class_bits, in_text_byte);
      end
    end
    due_count = scan_results_due.size();
  end

endmodule

// ===== test/char_class_run_scanner_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_class_run_scanner_top_test
// Drives the scanner with directed table and scan items, then with phases of
// random register settings, class layouts and byte runs, a long output
// hold-off and one unbroken run of scans with no idling on either side. A
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module char_class_run_scanner_top_test;
  import ccrs_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int RUN_LIMIT      = 2_000_000;
  // Longest silent item: a full range, which reads and writes back every byte.
  localparam int SETTLE_CYCLES  = 520;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int SHORT_ITEMS    = 30;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int STEADY_SCANS   = 150;

  // Codes that the package leaves unnamed.
  localparam logic [2:0] OP_UNUSED_LO   = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI   = 3'd7;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] CFG_UNUSED_LO  = 3'd4;
  localparam logic [2:0] CFG_UNUSED_HI  = 3'd7;
  localparam logic       KIND_COPY      = 1'b0;
  localparam logic       KIND_SKIP      = 1'b1;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [2:0]              in_operation = OP_RESTART;
  logic [ADDR_W-1:0]       in_range_from = '0;
  logic [ADDR_W-1:0]       in_range_to = '0;
  logic [PORT_CLASS_W-1:0] in_class_bits = '0;
  logic [ADDR_W-1:0]       in_text_byte = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PORT_CLASS_W-1:0] out_byte_class;
  logic [ADDR_W-1:0]       out_byte_echo;
  logic                    out_in_run;
  logic                    out_run_done;
  logic                    out_hit_end;
  logic [PORT_LEN_W-1:0]   out_run_length;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_MATCH_FLAGS;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int mismatch_count;
  int due_count;
  int checked_count;
  int run_byte_count;
  int stop_count;
  int eot_stop_count;

  int  cycle_count = 0;
  int  items_taken = 0;
  int  reg_writes = 0;
  int  steady_left = 0;
  logic pace_off = 1'b0;
  logic rx_quiet = 1'b0;
  logic squeeze_req = 1'b0;

  // Byte zones laid out in the table for the current phase.
  int                      zone_lo [3];
  int                      zone_hi [3];
  logic [PORT_CLASS_W-1:0] zone_cls [3];
  logic [ADDR_W-1:0]       eot_char;
  logic [PORT_CLASS_W-1:0] eot_val;

  char_class_run_scanner_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_range_from  (in_range_from),
    .in_range_to    (in_range_to),
    .in_class_bits  (in_class_bits),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_class (out_byte_class),
    .out_byte_echo  (out_byte_echo),
    .out_in_run     (out_in_run),
    .out_run_done   (out_run_done),
    .out_hit_end    (out_hit_end),
    .out_run_length (out_run_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  char_class_run_scanner_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_range_from  (in_range_from),
    .in_range_to    (in_range_to),
    .in_class_bits  (in_class_bits),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_class (out_byte_class),
    .out_byte_echo  (out_byte_echo),
    .out_in_run     (out_in_run),
    .out_run_done   (out_run_done),
    .out_hit_end    (out_hit_end),
    .out_run_length (out_run_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .due_count      (due_count),
    .checked_count  (checked_count),
    .run_byte_count (run_byte_count),
    .stop_count     (stop_count),
    .eot_stop_count (eot_stop_count)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Hard limit on the run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side pacing: short and long stalls, calm stretches, and one long
  // hold-off on request so that the block backs up into its input.
  initial begin : rx_pacing
    int hold_left;
    int calm_left;
    int roll;
    logic squeezed;
    hold_left = 0;
    calm_left = 0;
    squeezed = 1'b0;
    forever begin
      @(negedge clk);
      roll = $urandom_range(0, 99);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        hold_left = SQUEEZE_CYCLES - 1;
      end else if (rx_quiet || calm_left != 0) begin
        out_stall <= 1'b0;
        if (calm_left != 0) begin
          calm_left--;
        end
      end else if (roll < 70) begin
        out_stall <= 1'b0;
      end else if (roll < 95) begin
        out_stall <= 1'b1;
        hold_left = $urandom_range(0, 3);
      end else if (roll < 98) begin
        out_stall <= 1'b1;
        hold_left = $urandom_range(10, 60);
      end else begin
        out_stall <= 1'b0;
        calm_left = $urandom_range(20, 100);
      end
    end
  end

  // Offer one item after a random gap and wait until it is taken.
  task automatic offer_item(input logic [2:0] op, input logic [ADDR_W-1:0] lo,
                            input logic [ADDR_W-1:0] hi, input logic [PORT_CLASS_W-1:0] bits,
                            input logic [ADDR_W-1:0] ch);
    int gap;
    int roll;
    gap = 0;
    roll = $urandom_range(0, 99);
    if (pace_off || steady_left != 0) begin
      if (steady_left != 0) begin
        steady_left--;
      end
    end else if (roll < 28) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 36) begin
      gap = $urandom_range(4, 12);
    end else if (roll < 38) begin
      gap = $urandom_range(20, 60);
    end else if (roll < 40) begin
      steady_left = $urandom_range(30, 120);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_range_from <= lo;
    in_range_to <= hi;
    in_class_bits <= bits;
    in_text_byte <= ch;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (!(op > OP_RESTART || (op <= OP_CLR_RANGE && (lo == '0 || hi == '0 || lo > hi)))) begin
      items_taken++;
    end
  endtask

  task automatic scan(input logic [ADDR_W-1:0] ch);
    offer_item(OP_SCAN_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               16'($urandom), ch);
  endtask

  task automatic put_range(input logic [2:0] op, input logic [ADDR_W-1:0] lo,
                           input logic [ADDR_W-1:0] hi, input logic [PORT_CLASS_W-1:0] bits);
    offer_item(op, lo, hi, bits, 8'($urandom_range(0, 255)));
  endtask

  // Items whose fields other than the operation do not matter.
  task automatic plain_item(input logic [2:0] op);
    put_range(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every predicted result, then let a silent
  // range item finish.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_count != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic lay_out_zones();
    for (int z = 0; z < 3; z++) begin
      put_range(OP_SET_RANGE, 8'(zone_lo[z]), 8'(zone_hi[z]), zone_cls[z]);
    end
    put_range(OP_OR_RANGE, eot_char, eot_char, eot_val | 16'($urandom));
  endtask

  function automatic logic [ADDR_W-1:0] char_in_zone(input int z);
    return 8'($urandom_range(zone_lo[z], zone_hi[z]));
  endfunction

  initial begin : stimulus
    int quota;
    int run_bytes;
    int stay;
    int roll;
    int lo;
    int hi;
    logic [PORT_CLASS_W-1:0] flag_val;
    logic [2:0] mode_val;
    logic kind_val;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset settings: equal to zero, copy kind,
    // end of text on class bit 0.
    scan(8'h00);
    scan(8'hFF);
    put_range(OP_SET_RANGE, 8'd0, 8'd10, 16'hFFFF);    // zero low bound
    put_range(OP_SET_RANGE, 8'd10, 8'd0, 16'hFFFF);    // zero high bound
    put_range(OP_OR_RANGE, 8'd200, 8'd100, 16'hFFFF);  // reversed bounds
    put_range(OP_SET_RANGE, 8'd250, 8'd255, 16'h0001); // range up to the top entry
    put_range(OP_OR_RANGE, 8'd1, 8'd1, 16'h8000);
    plain_item(OP_UNUSED_LO);
    plain_item(OP_UNUSED_HI);
    scan(8'h01);                                       // test fails, run stops
    scan(8'hFF);                                       // scan after the stop
    plain_item(OP_RESTART);
    scan(8'hFE);                                       // end of text in copy kind
    scan(8'h02);
    put_range(OP_CLR_RANGE, 8'd250, 8'd255, 16'h0001);
    plain_item(OP_RESTART);
    scan(8'hFB);
    put_range(OP_SET_RANGE, 8'd1, 8'd255, 16'h0000);
    put_range(OP_OR_RANGE, 8'd1, 8'd255, 16'hFFFF);
    scan(8'h80);
    plain_item(OP_CLEAR_TABLE);
    plain_item(OP_RESTART);
    scan(8'h80);
    scan(8'h00);

    // Random phases, each with its own settings and class layout.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      mode_val = (p < 8) ? 3'(p) : 3'($urandom_range(MODE_EQUAL, MODE_NONE));
      kind_val = (p == 0) ? KIND_COPY : (p == 1) ? KIND_SKIP : 1'($urandom_range(0, 1));
      case (p)
        0: eot_val = 16'h0000;
        1: eot_val = 16'hFFFF;
        default: eot_val = ($urandom_range(0, 99) < 80) ?
                           16'(1 << $urandom_range(0, 15)) : 16'($urandom);
      endcase
      for (int z = 0; z < 3; z++) begin
        zone_lo[z] = $urandom_range(1, 255);
        hi = zone_lo[z] + (($urandom_range(0, 99) < 85) ?
                           $urandom_range(0, 15) : $urandom_range(0, 255));
        zone_hi[z] = (hi > 255) ? 255 : hi;
        zone_cls[z] = (($urandom_range(0, 1) == 0) ?
                       16'(1 << $urandom_range(0, 15)) : 16'($urandom)) & ~eot_val;
      end
      eot_char = 8'($urandom_range(1, 255));
      roll = $urandom_range(0, 99);
      if (p == 2) begin
        flag_val = 16'hFFFF;
      end else if (p == 3) begin
        flag_val = 16'h0000;
      end else if (roll < 50) begin
        flag_val = zone_cls[0];
      end else if (roll < 80) begin
        flag_val = zone_cls[0] & 16'($urandom);
      end else begin
        flag_val = 16'($urandom);
      end

      // Register writes, sometimes with junk above the narrow fields.
      write_reg(CFG_MATCH_FLAGS, flag_val);
      write_reg(CFG_MATCH_MODE, {(($urandom_range(0, 2) == 0) ? 13'($urandom) : 13'h0),
                                 mode_val});
      write_reg(CFG_SCAN_KIND, {(($urandom_range(0, 2) == 0) ? 15'($urandom) : 15'h0),
                                kind_val});
      write_reg(CFG_EOT_MASK, eot_val);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(3'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), 16'($urandom));
      end

      if ($urandom_range(0, 99) < 30) begin
        plain_item(OP_CLEAR_TABLE);
      end
      lay_out_zones();

      // Runs: copy kind draws mostly from the matching zone, skip kind from
      // the others, with noise mixed in.
      stay = (kind_val == KIND_SKIP) ? $urandom_range(1, 2) : 0;
      quota = items_taken + ((mode_val >= MODE_UNUSED_LO) ? SHORT_ITEMS : PHASE_ITEMS);
      while (items_taken < quota) begin
        plain_item(OP_RESTART);
        if (p == 2) begin
          squeeze_req = 1'b1;
        end
        run_bytes = $urandom_range(1, 40);
        repeat (run_bytes) begin
          roll = $urandom_range(0, 99);
          if (roll < 76) begin
            scan(char_in_zone(stay));
          end else if (roll < 84) begin
            scan(char_in_zone((stay + $urandom_range(1, 2)) % 3));
          end else if (roll < 88) begin
            scan(eot_char);
          end else if (roll < 92) begin
            scan(8'($urandom_range(0, 255)));
          end else if (roll < 94) begin
            scan((roll % 2 == 0) ? 8'h00 : 8'hFF);
          end else if (roll < 97) begin
            lo = $urandom_range(0, 255);
            hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                 lo + $urandom_range(0, 8);
            put_range(3'($urandom_range(OP_SET_RANGE, OP_CLR_RANGE)), 8'(lo),
                      8'((hi > 255) ? 255 : hi), 16'($urandom));
          end else if (roll < 98) begin
            plain_item(OP_CLEAR_TABLE);
            lay_out_zones();
          end else if (roll < 99) begin
            plain_item(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
          end else begin
            plain_item(OP_RESTART);
          end
        end
      end
    end

    // One unbroken run of class-zero bytes, back to back with no idling on
    // either side.
    drain();
    write_reg(CFG_MATCH_FLAGS, 16'h0000);
    write_reg(CFG_MATCH_MODE, {13'h0, MODE_EQUAL});
    write_reg(CFG_SCAN_KIND, {15'h0, KIND_COPY});
    write_reg(CFG_EOT_MASK, 16'h0001);
    plain_item(OP_CLEAR_TABLE);
    plain_item(OP_RESTART);
    pace_off = 1'b1;
    rx_quiet = 1'b1;
    repeat (STEADY_SCANS) scan(8'($urandom_range(0, 255)));
    pace_off = 1'b0;
    rx_quiet = 1'b0;

    drain();
    $display("Run covered %0d items and %0d register writes over %0d phases, one %0d-cycle",
             items_taken, reg_writes, PHASES, SQUEEZE_CYCLES);
    $display("output hold-off and %0d results: %0d bytes in runs, %0d stops, %0d at end of text.",
             checked_count, run_byte_count, stop_count, eot_stop_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
